// ===== rtl/core/desv_pkg.sv =====
// Package for the variable-round DES pipeline: FIPS 46 tables and bit permutations.
// No dependencies.
package desv_pkg;

    localparam int MAX_ROUNDS = 16;

    localparam int REG_KEY    = 0;
    localparam int REG_ROUNDS = 1;

    typedef logic [6:0] t_pos;

    localparam t_pos TAB_IP [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

    localparam t_pos TAB_IP_INV [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

    localparam t_pos TAB_E [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

    localparam t_pos TAB_P [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

    localparam t_pos TAB_PC1 [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

    localparam t_pos TAB_PC2 [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

    // cumulative left rotation of C and D after each round
    localparam int ROT_SUM [MAX_ROUNDS] = '{
        1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28};

    localparam logic [3:0] SBOX [8][4][16] = '{
        '{'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7}, '{0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8},
          '{4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0}, '{15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13}},
        '{'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10}, '{3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5},
          '{0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15}, '{13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9}},
        '{'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8}, '{13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1},
          '{13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7}, '{1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12}},
        '{'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15}, '{13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9},
          '{10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4}, '{3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14}},
        '{'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9}, '{14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6},
          '{4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14}, '{11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3}},
        '{'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11}, '{10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8},
          '{9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6}, '{4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13}},
        '{'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1}, '{13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6},
          '{1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2}, '{6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12}},
        '{'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7}, '{1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2},
          '{7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8}, '{2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}}};

    // bit 1 of DES is the MSB of every word
    function automatic logic [63:0] f_ip(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(TAB_IP[i])];
        return r;
    endfunction

    function automatic logic [63:0] f_ip_inv(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(TAB_IP_INV[i])];
        return r;
    endfunction

    function automatic logic [47:0] f_expand(input logic [31:0] x);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = x[32-int'(TAB_E[i])];
        return r;
    endfunction

    function automatic logic [31:0] f_perm_p(input logic [31:0] x);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) r[31-i] = x[32-int'(TAB_P[i])];
        return r;
    endfunction

    function automatic logic [27:0] f_rotl28(input logic [27:0] c, input int s);
        logic [55:0] t;
        t = {c, c} << s;
        return t[55:28];
    endfunction

    // subkey of round idx (0-based), straight from the key: wiring only
    function automatic logic [47:0] f_round_key(input logic [63:0] key, input int idx);
        logic [55:0] cd;
        logic [55:0] cdr;
        logic [47:0] k;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64-int'(TAB_PC1[i])];
        cdr = {f_rotl28(cd[55:28], ROT_SUM[idx]), f_rotl28(cd[27:0], ROT_SUM[idx])};
        for (int i = 0; i < 48; i++) k[47-i] = cdr[56-int'(TAB_PC2[i])];
        return k;
    endfunction

    function automatic logic [31:0] f_feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] x;
        logic [5:0]  b;
        logic [31:0] s;
        x = f_expand(r) ^ k;
        for (int j = 0; j < 8; j++) begin
            b = x[47-6*j -: 6];
            s[31-4*j -: 4] = SBOX[j][{b[5], b[0]}][b[4:1]];
        end
        return f_perm_p(s);
    endfunction

endpackage

// ===== rtl/core/desv_round.sv =====
// One Feistel round stage with its own valid/ready register slice.
// Depends on desv_pkg.
module desv_round
    import desv_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [4:0]  i_rounds,
    input  logic [47:0] i_subkey,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_left,
    input  logic [31:0] i_right,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_left,
    output logic [31:0] o_right
);

    logic        r_valid;
    logic [31:0] r_left, r_right;
    logic [31:0] n_left, n_right;
    logic [31:0] w_t;
    logic        w_apply;

    // rounds above sixteen behave as sixteen
    assign w_apply = (i_rounds > 5'(IDX));
    assign w_t     = i_left ^ f_feistel(i_right, i_subkey);

    always_comb begin
        n_left  = i_left;
        n_right = i_right;
        if (w_apply) begin
            if (IDX < MAX_ROUNDS - 1) begin
                n_left  = i_right;
                n_right = w_t;
            end else begin
                n_left  = w_t;
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_valid = r_valid;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

// ===== rtl/core/des_encrypt_variable_rounds.sv =====
// DES encryption, 0 to 16 rounds: initial permutation stage, sixteen round stages,
// final permutation output stage. One transaction per cycle while not stalled.
// Each stage holds its data while the next is full, so stalls lose nothing.
// Synchronous active-low reset clears all valid bits, key to 0, round count to 16.
module des_encrypt_variable_rounds
    import desv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_plain_block,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_cipher_block
);

    logic [63:0] r_key;
    logic [4:0]  r_rounds;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key    <= '0;
            r_rounds <= 5'(MAX_ROUNDS);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == 8'(REG_KEY))    r_key    <= i_cfg_data;
            if (i_cfg_index == 8'(REG_ROUNDS)) r_rounds <= i_cfg_data[4:0];
        end
    end

    // stage 0: initial permutation
    logic        r_ip_valid;
    logic [63:0] r_ip;
    logic        w_ip_ready;

    logic        w_vld [MAX_ROUNDS+1];
    logic        w_rdy [MAX_ROUNDS+1];
    logic [31:0] w_l   [MAX_ROUNDS+1];
    logic [31:0] w_r   [MAX_ROUNDS+1];

    assign o_in_ready = !r_ip_valid || w_ip_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_ip_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) r_ip <= f_ip(i_plain_block);
    end

    assign w_vld[0]   = r_ip_valid;
    assign w_ip_ready = w_rdy[0];
    assign w_l[0]     = r_ip[63:32];
    assign w_r[0]     = r_ip[31:0];

    for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_round
        desv_round #(.IDX(g)) u_round (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_rounds (r_rounds),
            .i_subkey (f_round_key(r_key, g)),
            .i_valid  (w_vld[g]),
            .o_ready  (w_rdy[g]),
            .i_left   (w_l[g]),
            .i_right  (w_r[g]),
            .o_valid  (w_vld[g+1]),
            .i_ready  (w_rdy[g+1]),
            .o_left   (w_l[g+1]),
            .o_right  (w_r[g+1])
        );
    end

    // output stage: inverse initial permutation
    logic        r_out_valid;
    logic [63:0] r_out;

    assign w_rdy[MAX_ROUNDS] = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rdy[MAX_ROUNDS]) begin
            r_out_valid <= w_vld[MAX_ROUNDS];
        end
        if (w_rdy[MAX_ROUNDS] && w_vld[MAX_ROUNDS]) begin
            r_out <= f_ip_inv({w_l[MAX_ROUNDS], w_r[MAX_ROUNDS]});
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cipher_block = r_out;

endmodule

// ===== rtl/core/desv_checker.sv =====
// Port-level checks for des_encrypt_variable_rounds, bound to the top level.
// No package dependency.
module desv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_cfg_ready,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_cipher_block
);

    // an empty output stage means every stage can advance
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready) else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cipher_block))
        else $error("output transaction dropped or changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid) else $error("output valid after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready) else $error("config port not ready");

endmodule

bind des_encrypt_variable_rounds desv_checker u_desv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_cfg_ready    (o_cfg_ready),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_cipher_block (o_cipher_block)
);

// ===== test/des_encrypt_variable_rounds_checker.sv =====
// Checker for the variable-round DES encryptor: watches the input and output channels,
// predicts each ciphertext from its own DES model and compares. Depends on desv_pkg.
module des_encrypt_variable_rounds_checker
    import desv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_plain_block,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_cipher_block,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_blocks_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam byte ROT_STEP [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    logic [63:0] key_reg;
    logic [4:0]  rounds_reg;
    logic [63:0] cipher_q [$];

    function automatic logic [31:0] round_func(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] x;
        logic [31:0] s;
        logic [31:0] p;
        int b;
        for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(TAB_E[i])];
        x = x ^ k;
        for (int j = 0; j < 8; j++) begin
            b = x[47-6*j -: 6];
            s[31-4*j -: 4] = SBOX[j][((b >> 4) & 2) | (b & 1)][(b >> 1) & 15];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32 - int'(TAB_P[i])];
        return p;
    endfunction

    function automatic logic [63:0] des_encrypt(input logic [63:0] pt, input logic [63:0] key,
                                                input logic [4:0] rounds);
        int n;
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        logic [55:0] cdr;
        logic [47:0] k;
        logic [63:0] ip;
        logic [31:0] lh;
        logic [31:0] rh;
        logic [31:0] t;
        logic [63:0] o;
        n = (rounds > 16) ? 16 : rounds;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64 - int'(TAB_PC1[i])];
        c = cd[55:28];
        d = cd[27:0];
        for (int i = 0; i < 64; i++) ip[63-i] = pt[64 - int'(TAB_IP[i])];
        lh = ip[63:32];
        rh = ip[31:0];
        for (int i = 0; i < n; i++) begin
            repeat (ROT_STEP[i]) begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            cdr = {c, d};
            for (int m = 0; m < 48; m++) k[47-m] = cdr[56 - int'(TAB_PC2[m])];
            t = lh ^ round_func(rh, k);
            if (i < 15) begin
                lh = rh;
                rh = t;
            end else begin
                lh = t;
            end
        end
        ip = {lh, rh};
        for (int i = 0; i < 64; i++) o[63-i] = ip[64 - int'(TAB_IP_INV[i])];
        return o;
    endfunction

    assign o_pending = cipher_q.size();

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (!i_rst_n) begin
            key_reg    <= '0;
            rounds_reg <= 5'd16;
            cipher_q.delete();
            o_fail_count     <= 0;
            o_blocks_checked <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_KEY) key_reg <= i_cfg_data;
                else if (i_cfg_index == REG_ROUNDS) rounds_reg <= i_cfg_data[4:0];
            end
            if (i_in_valid && i_in_ready)
                cipher_q.push_back(des_encrypt(i_plain_block, key_reg, rounds_reg));
            if (i_out_valid && i_out_ready) begin
                o_blocks_checked <= o_blocks_checked + 1;
                if (cipher_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected ciphertext %h", i_cipher_block);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = cipher_q.pop_front();
                    if (want !== i_cipher_block) begin
                        if (o_fail_count < 10)
                            $display("cipher_block mismatch: expected %h actual %h",
                                     want, i_cipher_block);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== test/tb_des_encrypt_variable_rounds.sv =====
// Top of the DES encryptor testbench: clock, reset, key/round settings and plaintext
// stimulus with random idling. Depends on desv_pkg, the encryptor and the checker.
module tb_des_encrypt_variable_rounds;
    import desv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 18;
    localparam int WDOG_MAX  = 4000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic [7:0]  i_cfg_index = 0;
    logic [63:0] i_cfg_data = 0;
    logic        i_in_valid = 0;
    logic [63:0] i_plain_block = 0;
    logic        i_out_ready = 0;
    logic        o_cfg_ready, o_in_ready, o_out_valid;
    logic [63:0] o_cipher_block;
    int          fail_count, pending, blocks_checked;
    int          idle_cycles = 0;
    int          configs_used = 0;
    bit          quiet_tail = 0;

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    des_encrypt_variable_rounds uut (.*);

    des_encrypt_variable_rounds_checker chk (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_in_valid, .i_in_ready(o_in_ready), .i_plain_block,
        .i_out_valid(o_out_valid), .i_out_ready, .i_cipher_block(o_cipher_block),
        .o_fail_count(fail_count), .o_pending(pending), .o_blocks_checked(blocks_checked));

    // receiver: bursts of stall, none in the tail
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            i_out_ready <= 1;
            n = $urandom_range(1, 30);
            repeat (n) @(posedge i_clk);
            if (!quiet_tail && $urandom_range(0, 1)) begin
                i_out_ready <= 0;
                n = $urandom_range(1, 18);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired, %0d ciphertexts outstanding", pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        configs_used++;
    endtask

    task automatic send_block(input logic [63:0] pt, input bit may_idle);
        int n;
        if (may_idle && !quiet_tail && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 0;
            n = $urandom_range(1, 18);
            repeat (n) @(posedge i_clk);
        end
        i_in_valid    <= 1;
        i_plain_block <= pt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic stop_sending();
        i_in_valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [63:0] keys [6];
        logic [4:0]  rnd;
        int per_phase;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset settings (key 0, 16 rounds), then known vector and extremes
        send_block(64'h0, 0);
        send_block(64'hFFFF_FFFF_FFFF_FFFF, 0);
        stop_sending();
        wait_drained();
        write_reg(8'(REG_KEY), 64'h1334_5779_9BBC_DFF1);
        send_block(64'h0123_4567_89AB_CDEF, 0);
        send_block(64'h8000_0000_0000_0001, 0);
        stop_sending();
        wait_drained();
        // round count zero, one, fifteen and above sixteen
        foreach (keys[i]) keys[i] = 0;
        for (int r = 0; r < 5; r++) begin
            rnd = (r == 0) ? 5'd0 : (r == 1) ? 5'd1 : (r == 2) ? 5'd15 :
                  (r == 3) ? 5'd17 : 5'd31;
            write_reg(8'(REG_ROUNDS), {59'd0, rnd});
            send_block(64'h0123_4567_89AB_CDEF, 0);
            send_block(64'hAAAA_5555_0F0F_F0F0, 0);
            stop_sending();
            wait_drained();
        end
        // ignored register index
        write_reg(8'hFF, rand64());
        write_reg(8'(REG_KEY), 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(8'(REG_ROUNDS), 64'd16);
        send_block(64'h0, 0);
        send_block(64'hFFFF_FFFF_FFFF_FFFF, 0);
        stop_sending();
        wait_drained();

        // random phases over keys and round counts
        keys[0] = 0;
        keys[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        for (int i = 2; i < 6; i++) keys[i] = rand64();
        per_phase = 1320 / 12;
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 11) quiet_tail = 1;
            write_reg(8'(REG_KEY), (ph < 6) ? keys[ph] : rand64());
            rnd = (ph % 4 == 0) ? 5'd16 : (ph % 4 == 1) ? 5'd1 : 5'($urandom_range(0, 31));
            write_reg(8'(REG_ROUNDS), {59'd0, rnd});
            for (int k = 0; k < per_phase; k++) begin
                send_block(rand64(), 1);
                if (ph == 5 && k == per_phase / 2) begin
                    // hold the sender until the pipe empties
                    stop_sending();
                    while (pending != 0) @(posedge i_clk);
                end
            end
            stop_sending();
            wait_drained();
        end

        $display("encrypted %0d blocks over %0d register writes, round counts 0..31",
                 blocks_checked, configs_used);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
